### rtl/tzb_pkg.sv
// Shared constants, payload types and command types of the triangle z-buffer fragment test.
package tzb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DEPTH_BITS = 16;
    localparam int ENTRIES    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(ENTRIES);

    localparam int KIND_W  = 2;
    localparam int VIDX_W  = 2;
    localparam int COORD_W = 16;
    localparam int PIX_W   = 10;
    localparam int COLOR_W = 24;
    localparam int DIM_W   = 11;

    localparam int FRAC_W  = 8;
    localparam int SCR_W   = COORD_W + 1 + DIM_W - FRAC_W;
    localparam int DIFF_W  = SCR_W + 1;
    localparam int DZ_W    = COORD_W + 1;
    localparam int MA_W    = 26;
    localparam int MB_W    = 21;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int U_W     = 2 * DIFF_W + 1;
    localparam int SPLIT   = 24;
    localparam int NUM_W   = 60;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam int DEGEN_LIMIT = 655;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [VIDX_W-1:0]         vertex_index;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic [PIX_W-1:0]          pixel_x;
        logic [PIX_W-1:0]          pixel_y;
        logic [COLOR_W-1:0]        fill_color;
    } frag_in_t;

    typedef struct packed {
        logic                         write_pixel;
        logic                         covered;
        logic [PIX_W-1:0]             out_x;
        logic [PIX_W-1:0]             out_y;
        logic [COLOR_W-1:0]           out_color;
        logic signed [DEPTH_BITS-1:0] out_depth;
    } frag_out_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [VIDX_W-1:0]         vidx;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic [PIX_W-1:0]          px;
        logic [PIX_W-1:0]          py;
        logic [COLOR_W-1:0]        color;
        logic                      in_store;
        logic [ADDR_W-1:0]         addr;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DEPTH_BITS-1:0] wr_data;
    } zmem_req_t;

endpackage

### rtl/tzb_front.sv
// Front end: accepts input items and classifies them into back-end commands.
module tzb_front (
    input  logic              item_valid,
    input  tzb_pkg::frag_in_t item,
    output logic              item_ready,
    input  logic              q_full,
    input  logic              clearing,
    output logic              push,
    output tzb_pkg::cmd_t     cmd
);
    import tzb_pkg::*;

    logic in_store;

    assign in_store = (32'(item.pixel_x) < MAX_WIDTH) && (32'(item.pixel_y) < MAX_HEIGHT);
    assign item_ready = !q_full && !clearing;
    assign push = item_valid && item_ready;

    always_comb
    begin
        cmd.vidx     = item.vertex_index;
        cmd.vx       = item.vert_x;
        cmd.vy       = item.vert_y;
        cmd.vz       = item.vert_z;
        cmd.px       = item.pixel_x;
        cmd.py       = item.pixel_y;
        cmd.color    = item.fill_color;
        cmd.in_store = in_store;
        cmd.addr     = ADDR_W'(ADDR_W'(item.pixel_x) * ADDR_W'(MAX_HEIGHT))
                     + ADDR_W'(item.pixel_y);
        case (item.kind)
            KIND_LOAD:  cmd.op = (item.vertex_index < VIDX_W'(3)) ? OP_LOAD : OP_NOP;
            KIND_TEST:  cmd.op = OP_TEST;
            KIND_CLEAR: cmd.op = in_store ? OP_CLEAR : OP_NOP;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

### rtl/tzb_fifo.sv
// Short command queue between the front end and the back end.
module tzb_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tzb_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output tzb_pkg::cmd_t rdata
);
    import tzb_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign valid = (count_reg != '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/tzb_div.sv
// Radix-2 signed divider, quotient truncated toward zero, one bit per cycle.
module tzb_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [tzb_pkg::NUM_W-1:0] num,
    input  logic signed [tzb_pkg::U_W-1:0]   den,
    output logic                             done,
    output logic signed [tzb_pkg::NUM_W-1:0] quot
);
    import tzb_pkg::*;

    logic [NUM_W-1:0] quo_reg;
    logic [U_W-1:0]   rem_reg;
    logic [U_W-1:0]   den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_mag;
    logic [U_W-1:0]   den_mag;
    logic [U_W:0]     trial;
    logic [U_W:0]     diff;
    logic             ge;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[U_W-1] ? U_W'(-den) : U_W'(den);
    assign trial   = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign ge      = (trial >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quot    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num_mag;
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[NUM_W-1] ^ den[U_W-1];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[U_W-1:0] : trial[U_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

endmodule

### rtl/tzb_zmem.sv
// Depth store memory with a clearing pass after reset and a registered read port.
module tzb_zmem (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tzb_pkg::zmem_req_t                    req,
    output logic signed [tzb_pkg::DEPTH_BITS-1:0] rd_data,
    output logic                                  clearing
);
    import tzb_pkg::*;

    logic [DEPTH_BITS-1:0] mem [ENTRIES];
    logic [DEPTH_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  clearing_reg;

    assign rd_data  = $signed(rd_data_reg);
    assign clearing = clearing_reg;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= DEPTH_MIN;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(ENTRIES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/tzb_back.sv
// Back end: sequencer with a shared multiplier for screen mapping, edges and depth update.
module tzb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  tzb_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output logic                          clearing,
    input  logic [tzb_pkg::DIM_W-1:0]     width,
    input  logic [tzb_pkg::DIM_W-1:0]     height,
    output logic                          result_valid,
    input  logic                          result_ready,
    output tzb_pkg::frag_out_t            result
);
    import tzb_pkg::*;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_MX0    = 5'd0;
    localparam logic [STEP_W-1:0] ST_MX1    = 5'd1;
    localparam logic [STEP_W-1:0] ST_MX2    = 5'd2;
    localparam logic [STEP_W-1:0] ST_MY0    = 5'd3;
    localparam logic [STEP_W-1:0] ST_MY1    = 5'd4;
    localparam logic [STEP_W-1:0] ST_MY2    = 5'd5;
    localparam logic [STEP_W-1:0] ST_DIFF   = 5'd6;
    localparam logic [STEP_W-1:0] ST_DREG   = 5'd7;
    localparam logic [STEP_W-1:0] ST_UX0    = 5'd8;
    localparam logic [STEP_W-1:0] ST_UX1    = 5'd9;
    localparam logic [STEP_W-1:0] ST_UY0    = 5'd10;
    localparam logic [STEP_W-1:0] ST_UY1    = 5'd11;
    localparam logic [STEP_W-1:0] ST_UZ0    = 5'd12;
    localparam logic [STEP_W-1:0] ST_UZ1    = 5'd13;
    localparam logic [STEP_W-1:0] ST_C1     = 5'd14;
    localparam logic [STEP_W-1:0] ST_C1R    = 5'd15;
    localparam logic [STEP_W-1:0] ST_DECIDE = 5'd16;
    localparam logic [STEP_W-1:0] ST_N0     = 5'd17;
    localparam logic [STEP_W-1:0] ST_N1     = 5'd18;
    localparam logic [STEP_W-1:0] ST_N2     = 5'd19;
    localparam logic [STEP_W-1:0] ST_N3     = 5'd20;
    localparam logic [STEP_W-1:0] ST_DIV    = 5'd21;
    localparam logic [STEP_W-1:0] ST_WAIT   = 5'd22;
    localparam logic [STEP_W-1:0] ST_FINAL  = 5'd23;

    localparam logic signed [U_W-1:0] DEGEN_POS = U_W'(DEGEN_LIMIT);
    localparam logic signed [U_W-1:0] DEGEN_NEG = U_W'(-DEGEN_LIMIT);
    localparam logic signed [NUM_W:0] SUM_MAX =
        {{(NUM_W+1-DEPTH_BITS){1'b0}}, DEPTH_MAX};
    localparam logic signed [NUM_W:0] SUM_MIN =
        {{(NUM_W+1-DEPTH_BITS){1'b1}}, DEPTH_MIN};

    function automatic logic signed [MA_W-1:0] map_arg(input logic [COORD_W-1:0] v);
        return {{(MA_W-COORD_W-1){1'b0}}, ~v[COORD_W-1], v[COORD_W-2:0]};
    endfunction

    function automatic logic signed [MB_W-1:0] dim_arg(input logic [DIM_W-1:0] d);
        return {{(MB_W-DIM_W){1'b0}}, d};
    endfunction

    function automatic logic signed [MA_W-1:0] da(input logic [DIFF_W-1:0] d);
        return {{(MA_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

    function automatic logic signed [MB_W-1:0] db(input logic [DIFF_W-1:0] d);
        return {{(MB_W-DIFF_W){d[DIFF_W-1]}}, d};
    endfunction

    function automatic logic signed [MB_W-1:0] dzb(input logic [DZ_W-1:0] d);
        return {{(MB_W-DZ_W){d[DZ_W-1]}}, d};
    endfunction

    function automatic logic signed [MA_W-1:0] lo_arg(input logic [U_W-1:0] u);
        return {{(MA_W-SPLIT){1'b0}}, u[SPLIT-1:0]};
    endfunction

    function automatic logic signed [MA_W-1:0] hi_arg(input logic [U_W-1:0] u);
        return {{(MA_W-U_W+SPLIT){u[U_W-1]}}, u[U_W-1:SPLIT]};
    endfunction

    logic                          busy_reg;
    logic [STEP_W-1:0]             step_reg;
    cmd_t                          cmd_reg;
    logic signed [COORD_W-1:0]     cx_reg [3];
    logic signed [COORD_W-1:0]     cy_reg [3];
    logic signed [COORD_W-1:0]     cz_reg [3];
    logic [COLOR_W-1:0]            color_reg;
    logic [SCR_W-1:0]              sx_reg [3];
    logic [SCR_W-1:0]              sy_reg [3];
    logic signed [DIFF_W-1:0]      s0x_reg, s0y_reg, s0z_reg;
    logic signed [DIFF_W-1:0]      s1x_reg, s1y_reg, s1z_reg;
    logic signed [DZ_W-1:0]        dz1_reg, dz2_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [U_W-1:0]         t_reg, ux_reg, uy_reg, uz_reg, c1_reg;
    logic signed [NUM_W-1:0]       num_reg;
    logic signed [DEPTH_BITS-1:0]  zold_reg;
    logic signed [DEPTH_BITS-1:0]  zsat_reg;
    logic                          result_valid_reg;
    frag_out_t                     result_reg;

    logic signed [MA_W-1:0]        mul_a;
    logic signed [MB_W-1:0]        mul_b;
    logic [SCR_W-1:0]              prod_scr;
    logic signed [U_W-1:0]         prod_u;
    logic signed [NUM_W-1:0]       prod_n;
    logic signed [DIFF_W-1:0]      qx, qy;
    logic                          covered;
    logic                          nondegen;
    logic                          write_ok;
    logic                          fin;
    logic                          fin_wr;
    logic                          fin_cov;
    logic signed [DEPTH_BITS-1:0]  fin_depth;
    logic                          out_free;
    zmem_req_t                     zreq;
    logic signed [DEPTH_BITS-1:0]  zrd;
    logic                          mem_clearing;
    logic                          div_start;
    logic                          div_done;
    logic signed [NUM_W-1:0]       div_quot;
    logic signed [NUM_W:0]         zsum;
    logic signed [DEPTH_BITS-1:0]  zsat;

    tzb_zmem u_zmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (zreq),
        .rd_data  (zrd),
        .clearing (mem_clearing)
    );

    tzb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (uz_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign clearing     = mem_clearing;
    assign cmd_pop      = cmd_valid && !busy_reg && !mem_clearing;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    assign prod_scr = prod_reg[SCR_W+FRAC_W-1:FRAC_W];
    assign prod_u   = prod_reg[U_W-1:0];
    assign prod_n   = {{(NUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign qx       = {{(DIFF_W-PIX_W-FRAC_W){1'b0}}, cmd_reg.px, {FRAC_W{1'b0}}};
    assign qy       = {{(DIFF_W-PIX_W-FRAC_W){1'b0}}, cmd_reg.py, {FRAC_W{1'b0}}};

    assign covered  = (ux_reg[U_W-1] == uy_reg[U_W-1]) && (uy_reg[U_W-1] == c1_reg[U_W-1]);
    assign nondegen = (uz_reg > DEGEN_POS) || (uz_reg < DEGEN_NEG);
    assign write_ok = cmd_reg.in_store && (zsat_reg > zold_reg);

    assign zsum = {{(NUM_W+1-COORD_W){cz_reg[0][COORD_W-1]}}, cz_reg[0]}
                + {div_quot[NUM_W-1], div_quot};
    assign zsat = (zsum > SUM_MAX) ? DEPTH_MAX
                : (zsum < SUM_MIN) ? DEPTH_MIN
                : zsum[DEPTH_BITS-1:0];

    assign div_start = busy_reg && (step_reg == ST_DIV);

    always_comb
    begin
        zreq.rd_addr = cmd_reg.addr;
        zreq.wr_addr = cmd_reg.addr;
        zreq.wr_en   = busy_reg && (((step_reg == ST_MX0) && (cmd_reg.op == OP_CLEAR))
                     || ((step_reg == ST_FINAL) && write_ok));
        zreq.wr_data = (step_reg == ST_FINAL) ? zsat_reg : DEPTH_MIN;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            ST_MX0:
            begin
                mul_a = map_arg(cx_reg[0]);
                mul_b = dim_arg(width);
            end
            ST_MX1:
            begin
                mul_a = map_arg(cx_reg[1]);
                mul_b = dim_arg(width);
            end
            ST_MX2:
            begin
                mul_a = map_arg(cx_reg[2]);
                mul_b = dim_arg(width);
            end
            ST_MY0:
            begin
                mul_a = map_arg(cy_reg[0]);
                mul_b = dim_arg(height);
            end
            ST_MY1:
            begin
                mul_a = map_arg(cy_reg[1]);
                mul_b = dim_arg(height);
            end
            ST_MY2:
            begin
                mul_a = map_arg(cy_reg[2]);
                mul_b = dim_arg(height);
            end
            ST_UX0:
            begin
                mul_a = da(s0y_reg);
                mul_b = db(s1z_reg);
            end
            ST_UX1:
            begin
                mul_a = da(s0z_reg);
                mul_b = db(s1y_reg);
            end
            ST_UY0:
            begin
                mul_a = da(s0z_reg);
                mul_b = db(s1x_reg);
            end
            ST_UY1:
            begin
                mul_a = da(s0x_reg);
                mul_b = db(s1z_reg);
            end
            ST_UZ0:
            begin
                mul_a = da(s0x_reg);
                mul_b = db(s1y_reg);
            end
            ST_UZ1:
            begin
                mul_a = da(s0y_reg);
                mul_b = db(s1x_reg);
            end
            ST_DECIDE:
            begin
                mul_a = lo_arg(uy_reg);
                mul_b = dzb(dz1_reg);
            end
            ST_N0:
            begin
                mul_a = hi_arg(uy_reg);
                mul_b = dzb(dz1_reg);
            end
            ST_N1:
            begin
                mul_a = lo_arg(ux_reg);
                mul_b = dzb(dz2_reg);
            end
            ST_N2:
            begin
                mul_a = hi_arg(ux_reg);
                mul_b = dzb(dz2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        fin       = 1'b0;
        fin_wr    = 1'b0;
        fin_cov   = 1'b0;
        fin_depth = '0;
        if (busy_reg)
        begin
            case (step_reg)
                ST_MX0:
                begin
                    fin = (cmd_reg.op != OP_TEST);
                end
                ST_DECIDE:
                begin
                    fin     = !covered || !nondegen;
                    fin_cov = covered;
                end
                ST_FINAL:
                begin
                    fin       = 1'b1;
                    fin_cov   = 1'b1;
                    fin_wr    = write_ok;
                    fin_depth = zsat_reg;
                end
                default:
                begin
                    fin = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (fin && out_free)
        begin
            result_reg.write_pixel <= fin_wr;
            result_reg.covered     <= fin_cov;
            result_reg.out_x       <= cmd_reg.px;
            result_reg.out_y       <= cmd_reg.py;
            result_reg.out_color   <= fin_wr ? color_reg : '0;
            result_reg.out_depth   <= fin_depth;
        end
        if (busy_reg)
        begin
            case (step_reg)
                ST_MX1:    sx_reg[0] <= prod_scr;
                ST_MX2:    sx_reg[1] <= prod_scr;
                ST_MY0:    sx_reg[2] <= prod_scr;
                ST_MY1:
                begin
                    sy_reg[0] <= prod_scr;
                    zold_reg  <= zrd;
                end
                ST_MY2:    sy_reg[1] <= prod_scr;
                ST_DIFF:   sy_reg[2] <= prod_scr;
                ST_DREG:
                begin
                    s0x_reg <= $signed({1'b0, sx_reg[1]}) - $signed({1'b0, sx_reg[0]});
                    s0y_reg <= $signed({1'b0, sx_reg[2]}) - $signed({1'b0, sx_reg[0]});
                    s0z_reg <= $signed({1'b0, sx_reg[0]}) - qx;
                    s1x_reg <= $signed({1'b0, sy_reg[1]}) - $signed({1'b0, sy_reg[0]});
                    s1y_reg <= $signed({1'b0, sy_reg[2]}) - $signed({1'b0, sy_reg[0]});
                    s1z_reg <= $signed({1'b0, sy_reg[0]}) - qy;
                    dz1_reg <= DZ_W'(cz_reg[1]) - DZ_W'(cz_reg[0]);
                    dz2_reg <= DZ_W'(cz_reg[2]) - DZ_W'(cz_reg[0]);
                end
                ST_UX1:    t_reg  <= prod_u;
                ST_UY0:    ux_reg <= t_reg - prod_u;
                ST_UY1:    t_reg  <= prod_u;
                ST_UZ0:    uy_reg <= t_reg - prod_u;
                ST_UZ1:    t_reg  <= prod_u;
                ST_C1:     uz_reg <= t_reg - prod_u;
                ST_C1R:    c1_reg <= uz_reg - ux_reg - uy_reg;
                ST_N0:     num_reg <= prod_n;
                ST_N1:     num_reg <= num_reg + (prod_n <<< SPLIT);
                ST_N2:     num_reg <= num_reg + prod_n;
                ST_N3:     num_reg <= num_reg + (prod_n <<< SPLIT);
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        zsat_reg <= zsat;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
                cz_reg[i] <= '0;
            end
            color_reg <= '0;
        end
        else if (busy_reg && (step_reg == ST_MX0) && (cmd_reg.op == OP_LOAD))
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cmd_reg.vidx == VIDX_W'(i))
                begin
                    cx_reg[i] <= cmd_reg.vx;
                    cy_reg[i] <= cmd_reg.vy;
                    cz_reg[i] <= cmd_reg.vz;
                end
            end
            color_reg <= cmd_reg.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            step_reg         <= ST_MX0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            if (!busy_reg)
            begin
                if (cmd_pop)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= ST_MX0;
                end
            end
            else if (fin)
            begin
                if (out_free)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (step_reg == ST_WAIT)
            begin
                if (div_done)
                begin
                    step_reg <= ST_FINAL;
                end
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (busy_reg && (step_reg == ST_WAIT)))
        else $error("divider finished outside the wait step");

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        zreq.wr_en |-> !mem_clearing)
        else $error("depth write during clearing pass");

    a_write_implies_covered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.write_pixel || result_reg.covered))
        else $error("pixel write reported for an uncovered pixel");

    a_uncovered_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.covered) |->
            ((result_reg.out_depth == '0) && (result_reg.out_color == '0)))
        else $error("uncovered result carries depth or color");

endmodule

### rtl/triangle_zbuffer_fragment_test.sv
// Top level of the triangle z-buffer fragment test with its APB configuration registers.
// Vertex load, depth clear and ignored items give a result from the first back-end step.
// A pixel test ends at the coverage and shape decision when rejected there, and otherwise
// reaches the depth update through the 60-step radix-2 divider.
// Throughput: the back end carries one item at a time; a 2-entry queue buffers the front end.
// Reset: the depth store's 1048576 entries are cleared in a pass; no item is accepted meanwhile.
module triangle_zbuffer_fragment_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tzb_pkg::frag_in_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output tzb_pkg::frag_out_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tzb_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    logic             clearing;
    cmd_t             push_cmd;
    cmd_t             head_cmd;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(800);
            height_reg <= DIM_W'(800);
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tzb_front u_front (
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .cmd        (push_cmd)
    );

    tzb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .full  (q_full),
        .pop   (pop),
        .valid (q_valid),
        .rdata (head_cmd)
    );

    tzb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .clearing     (clearing),
        .width        (width_reg),
        .height       (height_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
